// ===== hdl/global_align_affine_trace_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GLOBAL_ALIGN_AFFINE_TRACE_UNIT_ASSERT_SVH
`define GLOBAL_ALIGN_AFFINE_TRACE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GAAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GAAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gaat_pkg.sv =====
// Shared types, constants and arithmetic helpers for the affine-gap trace unit.
`default_nettype none
package gaat_pkg;

   localparam int MAX_QUERY   = 64;
   localparam int ALPHABET    = 32;
   localparam int SCORE_BITS  = 32;
   localparam int ROW_BITS    = 6;
   localparam int SYM_BITS    = 5;
   localparam int LEN_BITS    = 7;
   localparam int GAP_BITS    = 8;
   localparam int VALUE_BITS  = 8;
   localparam int COL_BITS    = 16;
   localparam int TADDR_BITS  = ROW_BITS + SYM_BITS;
   localparam int TABLE_DEPTH = 1 << TADDR_BITS;
   localparam int WIDE_BITS   = SCORE_BITS + 2;
   localparam int TRACE_BITS  = 7;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP_OPEN     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP_EXTEND   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUERY_LENGTH = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROFILE_MODE = 2'd3;

   localparam logic [1:0] CMD_LOAD_SCORE = 2'd0;
   localparam logic [1:0] CMD_LOAD_QUERY = 2'd1;
   localparam logic [1:0] CMD_DATABASE   = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   localparam int TR_E_OPEN = 0;
   localparam int TR_E_EXT  = 1;
   localparam int TR_F_OPEN = 2;
   localparam int TR_F_EXT  = 3;
   localparam int TR_DIAG   = 4;
   localparam int TR_INS    = 5;
   localparam int TR_DEL    = 6;

   localparam logic signed [WIDE_BITS-1:0] SC_MAX_W =
      {{(WIDE_BITS-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] SC_MIN_W = ~SC_MAX_W;
   localparam logic signed [SCORE_BITS-1:0] NEG_INF =
      {2'b11, {(SCORE_BITS-2){1'b0}}};

   typedef enum logic [1:0] {
      OP_SCORE  = 2'd0,
      OP_QUERY  = 2'd1,
      OP_COLUMN = 2'd2
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [ROW_BITS-1:0]           row;
      logic [SYM_BITS-1:0]           symbol;
      logic signed [VALUE_BITS-1:0]  score_value;
      logic                          last;
   } item_type;

   typedef struct packed {
      logic [GAP_BITS-1:0] gap_open;
      logic [GAP_BITS-1:0] gap_extend;
      logic [LEN_BITS-1:0] query_length;
      logic                profile_mode;
   } cfg_type;

   function automatic logic signed [WIDE_BITS-1:0] wext(input logic signed [SCORE_BITS-1:0] x);
      return {{(WIDE_BITS-SCORE_BITS){x[SCORE_BITS-1]}}, x};
   endfunction

   function automatic logic signed [WIDE_BITS-1:0] wgap(input logic [GAP_BITS-1:0] g);
      return {{(WIDE_BITS-GAP_BITS){1'b0}}, g};
   endfunction

   function automatic logic signed [SCORE_BITS-1:0] sat(input logic signed [WIDE_BITS-1:0] x);
      logic signed [SCORE_BITS-1:0] r;
      if (x > SC_MAX_W) begin
         r = SC_MAX_W[SCORE_BITS-1:0];
      end else if (x < SC_MIN_W) begin
         r = SC_MIN_W[SCORE_BITS-1:0];
      end else begin
         r = x[SCORE_BITS-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/gaat_front.sv =====
// Front end: accepts transactions, classifies commands, drops unused ones and queues the rest for the engine.
`default_nettype none
module gaat_front import gaat_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [ROW_BITS-1:0]           req_row,
   input  wire logic [SYM_BITS-1:0]           req_symbol,
   input  wire logic signed [VALUE_BITS-1:0]  req_score_value,
   input  wire logic                          req_end_of_database,
   output      logic                          q_valid,
   output      item_type                      q_item,
   input  wire logic                          q_pop
);

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       keep;
   item_type   push_item;

   always_comb begin
      keep                  = 1'b1;
      push_item.op          = OP_COLUMN;
      push_item.row         = req_row;
      push_item.symbol      = req_symbol;
      push_item.score_value = req_score_value;
      push_item.last        = req_end_of_database;
      unique case (req_cmd)
         CMD_LOAD_SCORE: push_item.op = OP_SCORE;
         CMD_LOAD_QUERY: push_item.op = OP_QUERY;
         CMD_DATABASE:   push_item.op = OP_COLUMN;
         CMD_UNUSED:     keep = 1'b0;
         default:        keep = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/gaat_back.sv =====
// Back end: executes loads and walks the query rows of each database symbol.
`default_nettype none
module gaat_back import gaat_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfg_type                       cfg,
   input  wire logic                          q_valid,
   input  wire item_type                      q_item,
   output      logic                          q_pop,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [ROW_BITS-1:0]           rsp_query_row,
   output      logic [TRACE_BITS-1:0]         rsp_trace_code,
   output      logic signed [SCORE_BITS-1:0]  rsp_cell_score,
   output      logic                          rsp_last_row,
   output      logic                          rsp_alignment_done
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_RD    = 6'b000100,
      S_TB    = 6'b001000,
      S_CE    = 6'b010000,
      S_CF    = 6'b100000
   } state_type;

   logic signed [VALUE_BITS-1:0] score_mem [TABLE_DEPTH];
   logic [SYM_BITS-1:0]          qsym_mem  [MAX_QUERY];
   logic signed [SCORE_BITS-1:0] h_mem     [MAX_QUERY];
   logic signed [SCORE_BITS-1:0] e_mem     [MAX_QUERY];

   state_type                    state_ff, state_in;
   logic [ROW_BITS-1:0]          row_ff, row_in;
   logic [COL_BITS-1:0]          col_ff, col_in;
   logic [MAX_QUERY-1:0]         valid_ff, valid_in;
   logic                         out_valid_ff, out_valid_in;

   logic [SYM_BITS-1:0]          sym_ff;
   logic                         last_ff;
   logic [GAP_BITS-1:0]          iopen_ff;
   logic [GAP_BITS-1:0]          iext_ff;
   logic signed [SCORE_BITS-1:0] top_bound_ff;
   logic signed [SCORE_BITS-1:0] top_pre_ff;
   logic signed [SCORE_BITS-1:0] hdiag_ff;
   logic signed [SCORE_BITS-1:0] hprev_ff;
   logic signed [SCORE_BITS-1:0] ft_ff;
   logic signed [SCORE_BITS-1:0] htprev_ff;
   logic signed [SCORE_BITS-1:0] h_rd_ff;
   logic signed [SCORE_BITS-1:0] e_rd_ff;
   logic [SYM_BITS-1:0]          qsym_rd_ff;
   logic signed [VALUE_BITS-1:0] score_rd_ff;
   logic signed [SCORE_BITS-1:0] hold_ff;
   logic signed [SCORE_BITS-1:0] eold_ff;
   logic signed [SCORE_BITS-1:0] ht_ff;
   logic                         ex_ff;
   logic [1:0]                   ecode_ff;

   logic [ROW_BITS-1:0]          out_row_ff;
   logic [TRACE_BITS-1:0]        out_code_ff;
   logic signed [SCORE_BITS-1:0] out_score_ff;
   logic                         out_last_ff;
   logic                         out_done_ff;

   logic [LEN_BITS-1:0]          len;
   logic [ROW_BITS-1:0]          last_idx;
   logic                         out_free;
   logic                         cf_fire;
   logic                         start_col;
   logic [TADDR_BITS-1:0]        score_raddr;
   logic [ROW_BITS-1:0]          trow;
   logic [ROW_BITS+GAP_BITS-1:0] init_prod;
   logic signed [SCORE_BITS-1:0] init_h;
   logic [COL_BITS+GAP_BITS-1:0] top_prod;
   logic signed [SCORE_BITS-1:0] top_pre;

   logic signed [WIDE_BITS-1:0]  eo, ee, hd, fext, fopn;
   logic signed [SCORE_BITS-1:0] e_new, ht, pre, ftn, h_new;
   logic                         ex;
   logic [1:0]                   ecode;
   logic [1:0]                   fcode;
   logic [2:0]                   hcode;

   always_comb begin
      if (cfg.query_length == '0) begin
         len = LEN_BITS'(1);
      end else if (cfg.query_length > LEN_BITS'(MAX_QUERY)) begin
         len = LEN_BITS'(MAX_QUERY);
      end else begin
         len = cfg.query_length;
      end
      last_idx = ROW_BITS'(len - LEN_BITS'(1));
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign cf_fire   = (state_ff == S_CF) && out_free;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign start_col = q_pop && (q_item.op == OP_COLUMN) && (col_ff == '0);

   assign trow        = cfg.profile_mode ? row_ff : {1'b0, qsym_rd_ff};
   assign score_raddr = {trow, sym_ff};
   assign init_prod   = {{GAP_BITS{1'b0}}, row_ff} * {{ROW_BITS{1'b0}}, iext_ff};
   assign init_h      = sat(-wgap(iopen_ff) - {{(WIDE_BITS-ROW_BITS-GAP_BITS){1'b0}}, init_prod});
   assign top_prod    = {{GAP_BITS{1'b0}}, col_ff} * {{COL_BITS{1'b0}}, cfg.gap_extend};
   assign top_pre     = sat(-wgap(cfg.gap_open)
                            - {{(WIDE_BITS-COL_BITS-GAP_BITS){1'b0}}, top_prod});

   // E and provisional H
   always_comb begin
      eo    = wext(hold_ff) - wgap(cfg.gap_open);
      ee    = wext(eold_ff) - wgap(cfg.gap_extend);
      e_new = sat((eo > ee) ? eo : ee);
      ecode = (eo > ee) ? 2'b01 : 2'b10;
      hd    = wext(hdiag_ff) + {{(WIDE_BITS-VALUE_BITS){score_rd_ff[VALUE_BITS-1]}}, score_rd_ff};
      ht    = sat((hd > wext(e_new)) ? hd : wext(e_new));
      ex    = wext(e_new) > hd;
   end

   // F scan step and final H
   always_comb begin
      pre   = (row_ff == '0) ? top_pre_ff : htprev_ff;
      fext  = wext(ft_ff) - wgap(cfg.gap_extend);
      ftn   = sat((wext(pre) >= fext) ? wext(pre) : fext);
      fopn  = wext(ftn) - wgap(cfg.gap_open);
      fcode = (wext(hprev_ff) > fext) ? 2'b01 : 2'b10;
      if (wext(ht_ff) > fopn) begin
         h_new = ht_ff;
         hcode = ex_ff ? 3'b010 : 3'b001;
      end else begin
         h_new = sat(fopn);
         if (wext(ht_ff) == fopn) begin
            hcode = ex_ff ? 3'b100 : 3'b001;
         end else begin
            hcode = 3'b100;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      valid_in     = valid_ff;
      out_valid_in = rsp_stall ? out_valid_ff : 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop && (q_item.op == OP_COLUMN)) begin
               state_in = S_START;
               if (col_ff == '0) begin
                  valid_in = '0;
               end
            end
         end
         S_START: begin
            row_in   = '0;
            state_in = S_RD;
         end
         S_RD: state_in = S_TB;
         S_TB: state_in = S_CE;
         S_CE: state_in = S_CF;
         S_CF: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               valid_in[row_ff] = 1'b1;
               if (row_ff == last_idx) begin
                  state_in = S_IDLE;
                  if (last_ff) begin
                     col_in = '0;
                  end else if (col_ff != '1) begin
                     col_in = col_ff + COL_BITS'(1);
                  end
               end else begin
                  row_in   = row_ff + ROW_BITS'(1);
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.op == OP_SCORE)) begin
         score_mem[{q_item.row, q_item.symbol}] <= q_item.score_value;
      end
      if (state_ff == S_TB) begin
         score_rd_ff <= score_mem[score_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.op == OP_QUERY)) begin
         qsym_mem[q_item.row] <= q_item.symbol;
      end
      if (state_ff == S_RD) begin
         qsym_rd_ff <= qsym_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cf_fire) begin
         h_mem[row_ff] <= h_new;
      end
      if (state_ff == S_RD) begin
         h_rd_ff <= h_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CE) begin
         e_mem[row_ff] <= e_new;
      end
      if (state_ff == S_RD) begin
         e_rd_ff <= e_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.op == OP_COLUMN)) begin
         sym_ff  <= q_item.symbol;
         last_ff <= q_item.last;
      end
      if (start_col) begin
         iopen_ff     <= cfg.gap_open;
         iext_ff      <= cfg.gap_extend;
         top_bound_ff <= '0;
      end
      if (state_ff == S_START) begin
         top_pre_ff <= top_pre;
         hdiag_ff   <= top_bound_ff;
         hprev_ff   <= top_bound_ff;
         ft_ff      <= NEG_INF;
      end
      if (state_ff == S_TB) begin
         hold_ff <= valid_ff[row_ff] ? h_rd_ff : init_h;
         eold_ff <= valid_ff[row_ff] ? e_rd_ff : NEG_INF;
      end
      if (state_ff == S_CE) begin
         ht_ff    <= ht;
         ex_ff    <= ex;
         ecode_ff <= ecode;
         hdiag_ff <= hold_ff;
      end
      if (cf_fire) begin
         hprev_ff     <= h_new;
         htprev_ff    <= ht_ff;
         ft_ff        <= ftn;
         out_row_ff   <= row_ff;
         out_code_ff  <= {hcode, fcode, ecode_ff};
         out_score_ff <= h_new;
         out_last_ff  <= (row_ff == last_idx);
         out_done_ff  <= (row_ff == last_idx) && last_ff;
         if (row_ff == last_idx) begin
            top_bound_ff <= top_pre_ff;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_query_row      = out_row_ff;
   assign rsp_trace_code     = out_code_ff;
   assign rsp_cell_score     = out_score_ff;
   assign rsp_last_row       = out_last_ff;
   assign rsp_alignment_done = out_done_ff;

endmodule
`default_nettype wire

// ===== hdl/global_align_affine_trace_unit.sv =====
// Top level of the affine-gap global alignment trace unit.
`default_nettype none
// Global alignment with affine gaps and traceback codes. Load transactions fill the
// score table and query symbols; each database-symbol transaction yields one result
// per query row in use (rows 0 to query_length-1, a zero length taken as 1 and longer
// lengths capped at 64), carrying the trace code and new H. Each database symbol
// walks the rows through the H/E column memories and the score table, one
// read-look-up-update pass per row. A two-entry queue decouples input acceptance
// from the engine. No clearing pass follows reset.
module global_align_affine_trace_unit import gaat_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [GAP_BITS-1:0]           csr_write_data,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [ROW_BITS-1:0]           req_row,
   input  wire logic [SYM_BITS-1:0]           req_symbol,
   input  wire logic signed [VALUE_BITS-1:0]  req_score_value,
   input  wire logic                          req_end_of_database,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [ROW_BITS-1:0]           rsp_query_row,
   output      logic [TRACE_BITS-1:0]         rsp_trace_code,
   output      logic signed [SCORE_BITS-1:0]  rsp_cell_score,
   output      logic                          rsp_last_row,
   output      logic                          rsp_alignment_done
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAP_OPEN:     cfg_in.gap_open     = csr_write_data;
            CSR_GAP_EXTEND:   cfg_in.gap_extend   = csr_write_data;
            CSR_QUERY_LENGTH: cfg_in.query_length = csr_write_data[LEN_BITS-1:0];
            CSR_PROFILE_MODE: cfg_in.profile_mode = csr_write_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_open     <= GAP_BITS'(10);
         cfg_ff.gap_extend   <= GAP_BITS'(1);
         cfg_ff.query_length <= LEN_BITS'(MAX_QUERY);
         cfg_ff.profile_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gaat_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_row             (req_row),
      .req_symbol          (req_symbol),
      .req_score_value     (req_score_value),
      .req_end_of_database (req_end_of_database),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop)
   );

   gaat_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_query_row      (rsp_query_row),
      .rsp_trace_code     (rsp_trace_code),
      .rsp_cell_score     (rsp_cell_score),
      .rsp_last_row       (rsp_last_row),
      .rsp_alignment_done (rsp_alignment_done)
   );

endmodule
`default_nettype wire

// ===== hdl/gaat_checker.sv =====
// Port-level checker for the trace unit, bound to the top level.
`default_nettype none
`include "global_align_affine_trace_unit_assert.svh"
module gaat_checker import gaat_pkg::*; (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [ROW_BITS-1:0]           rsp_query_row,
   input wire logic [TRACE_BITS-1:0]         rsp_trace_code,
   input wire logic signed [SCORE_BITS-1:0]  rsp_cell_score,
   input wire logic                          rsp_last_row,
   input wire logic                          rsp_alignment_done
);

   logic                              rsp_fire;
   logic                              row_moved;
   logic [ROW_BITS-1:0]               row_seen_ff;
   logic [SCORE_BITS+TRACE_BITS-1:0]  payload;

   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign payload   = {rsp_cell_score, rsp_trace_code};
   assign row_moved = !rsp_valid || (rsp_query_row != row_seen_ff);

   always_ff @(posedge clock) begin
      row_seen_ff <= rsp_query_row;
   end

   `GAAT_ASSERT_NOW(a_done_on_last, rsp_valid && rsp_alignment_done, rsp_last_row, "early done")
   `GAAT_ASSERT_NEXT(a_row_advances, rsp_fire && !rsp_last_row, row_moved, "row repeated")
   `GAAT_ASSERT_NEXT(a_valid_held, rsp_valid && rsp_stall, rsp_valid, "transaction dropped")
   `GAAT_ASSERT_NEXT(a_score_held, rsp_valid && rsp_stall, $stable(payload), "payload changed")

endmodule

bind global_align_affine_trace_unit gaat_checker u_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the affine-gap global alignment trace unit.
`timescale 1ns / 1ps
module tb_top;
   import gaat_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PRELOAD_ROWS = ALPHABET;
   localparam int DB_SYMS = 2;
   localparam int RAND_ITEMS = 20;
   localparam longint NEG_INF_L = -(64'sd1 <<< 30);

   typedef struct {
      logic [ROW_BITS-1:0]          qrow;
      logic [TRACE_BITS-1:0]        code;
      logic signed [SCORE_BITS-1:0] score;
      logic                         last;
      logic                         done;
   } trace_type;

   typedef struct {
      logic [1:0]                   cmd;
      logic [ROW_BITS-1:0]          row;
      logic [SYM_BITS-1:0]          sym;
      logic signed [VALUE_BITS-1:0] val;
      logic                         eod;
      logic                         typed;
      logic [TRACE_BITS-1:0]        code;
      logic signed [SCORE_BITS-1:0] score;
   } stim_type;

   typedef struct {
      int open_pen;
      int ext_pen;
      int len;
      int profile;
      int send_idle;
      int recv_idle;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [GAP_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_UNUSED;
   logic [ROW_BITS-1:0] req_row = '0;
   logic [SYM_BITS-1:0] req_symbol = '0;
   logic signed [VALUE_BITS-1:0] req_score_value = '0;
   logic req_end_of_database = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ROW_BITS-1:0] rsp_query_row;
   logic [TRACE_BITS-1:0] rsp_trace_code;
   logic signed [SCORE_BITS-1:0] rsp_cell_score;
   logic rsp_last_row;
   logic rsp_alignment_done;

   global_align_affine_trace_unit u_top (.*);

   // predictor state
   byte               sub_table[TABLE_DEPTH];
   logic [SYM_BITS-1:0] query_sym[MAX_QUERY];
   longint            h_col[MAX_QUERY];
   longint            e_col[MAX_QUERY];
   int                col_idx;
   longint            h_top;
   int                cfg_open = 10, cfg_ext = 1, cfg_len = 64, cfg_profile = 0;

   trace_type         trace_q[$];
   int                errors = 0;
   int                cycles = 0;
   int                send_idle = 0, recv_idle = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL global_align_affine_trace_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle);
   end

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic void init_columns();
      for (int i = 0; i < MAX_QUERY; i++) begin
         h_col[i] = sat32(-longint'(cfg_open) - longint'(i) * cfg_ext);
         e_col[i] = NEG_INF_L;
      end
      col_idx = 0;
      h_top = 0;
   endfunction

   function automatic void predict_column(logic [SYM_BITS-1:0] sym, logic eod);
      longint ht[MAX_QUERY];
      bit ex[MAX_QUERY];
      logic [TRACE_BITS-1:0] code[MAX_QUERY];
      longint eo, ee, hd, ft, hprev, pre, fext, fopn, hv, j;
      int n, trow;
      trace_type r;
      n = (cfg_len == 0) ? 1 : (cfg_len > MAX_QUERY ? MAX_QUERY : cfg_len);
      if (col_idx == 0) init_columns();
      j = col_idx;
      for (int i = 0; i < n; i++) begin
         eo = h_col[i] - cfg_open;
         ee = e_col[i] - cfg_ext;
         e_col[i] = sat32(eo > ee ? eo : ee);
         code[i] = '0;
         code[i][eo > ee ? TR_E_OPEN : TR_E_EXT] = 1'b1;
         trow = cfg_profile ? i : int'(query_sym[i]);
         hd = (i == 0 ? h_top : h_col[i-1]) + longint'(sub_table[trow * ALPHABET + sym]);
         ht[i] = sat32(hd > e_col[i] ? hd : e_col[i]);
         ex[i] = e_col[i] > hd;
      end
      ft = NEG_INF_L;
      hprev = h_top;
      for (int i = 0; i < n; i++) begin
         pre = (i == 0) ? sat32(-longint'(cfg_open) - j * cfg_ext) : ht[i-1];
         fext = ft - cfg_ext;
         ft = sat32(pre >= fext ? pre : fext);
         fopn = ft - cfg_open;
         code[i][hprev > fext ? TR_F_OPEN : TR_F_EXT] = 1'b1;
         if (ht[i] > fopn) begin
            hv = ht[i];
            code[i][ex[i] ? TR_INS : TR_DIAG] = 1'b1;
         end else begin
            hv = sat32(fopn);
            code[i][(ht[i] == fopn && !ex[i]) ? TR_DIAG : TR_DEL] = 1'b1;
         end
         h_col[i] = hv;
         hprev = hv;
         r.qrow = ROW_BITS'(i);
         r.code = code[i];
         r.score = SCORE_BITS'(hv);
         r.last = (i == n - 1);
         r.done = (i == n - 1) && eod;
         trace_q.push_back(r);
      end
      h_top = sat32(-longint'(cfg_open) - j * cfg_ext);
      if (col_idx < 65535) col_idx++;
      if (eod) init_columns();
   endfunction

   function automatic void predict_item(stim_type s);
      case (s.cmd)
         CMD_LOAD_SCORE: sub_table[s.row * ALPHABET + s.sym] = s.val;
         CMD_LOAD_QUERY: query_sym[s.row] = s.sym;
         CMD_DATABASE:   predict_column(s.sym, s.eod);
         default: ;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      trace_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (trace_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected transaction: row %0d code %0h score %0d",
                        rsp_query_row, rsp_trace_code, rsp_cell_score);
         end else begin
            x = trace_q.pop_front();
            if (rsp_query_row !== x.qrow || rsp_trace_code !== x.code ||
                rsp_cell_score !== x.score || rsp_last_row !== x.last ||
                rsp_alignment_done !== x.done) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp row %0d code %0h score %0d last %0b done %0b,",
                            " got row %0d code %0h score %0d last %0b done %0b"},
                           x.qrow, x.code, x.score, x.last, x.done, rsp_query_row,
                           rsp_trace_code, rsp_cell_score, rsp_last_row,
                           rsp_alignment_done);
            end
         end
      end
   end

   task automatic send(stim_type s);
      trace_type r;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= s.cmd;
      req_row <= s.row;
      req_symbol <= s.sym;
      req_score_value <= s.val;
      req_end_of_database <= s.eod;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(s);
      if (s.typed) begin
         r = trace_q.pop_back();
         r.code = s.code;
         r.score = s.score;
         trace_q.push_back(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (trace_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[GAP_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic configure(phase_type p);
      csr_write(CSR_GAP_OPEN, p.open_pen);
      csr_write(CSR_GAP_EXTEND, p.ext_pen);
      csr_write(CSR_QUERY_LENGTH, p.len);
      csr_write(CSR_PROFILE_MODE, p.profile);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      cfg_open = p.open_pen;
      cfg_ext = p.ext_pen;
      cfg_len = p.len;
      cfg_profile = p.profile;
      send_idle = p.send_idle;
      recv_idle = p.recv_idle;
   endtask

   stim_type directed[] = '{
      '{CMD_LOAD_QUERY, 6'd0,  5'd5,  8'sd0,    1'b0, 1'b0, 7'd0, 0},
      '{CMD_LOAD_SCORE, 6'd5,  5'd3,  8'sd127,  1'b0, 1'b0, 7'd0, 0},
      '{CMD_DATABASE,   6'd0,  5'd3,  8'sd0,    1'b1, 1'b1,
        7'((1 << TR_E_OPEN) | (1 << TR_F_OPEN) | (1 << TR_DIAG)), 127},
      '{CMD_LOAD_SCORE, 6'd5,  5'd4,  -8'sd128, 1'b0, 1'b0, 7'd0, 0},
      '{CMD_DATABASE,   6'd0,  5'd4,  8'sd0,    1'b1, 1'b1,
        7'((1 << TR_E_OPEN) | (1 << TR_F_OPEN) | (1 << TR_DEL)), -20},
      '{CMD_UNUSED,     6'd63, 5'd31, -8'sd1,   1'b1, 1'b0, 7'd0, 0},
      '{CMD_LOAD_SCORE, 6'd5,  5'd31, -8'sd128, 1'b0, 1'b0, 7'd0, 0},
      '{CMD_LOAD_QUERY, 6'd63, 5'd31, 8'sd0,    1'b0, 1'b0, 7'd0, 0},
      '{CMD_LOAD_SCORE, 6'd0,  5'd0,  8'sd0,    1'b0, 1'b0, 7'd0, 0},
      '{CMD_DATABASE,   6'd0,  5'd31, 8'sd0,    1'b0, 1'b0, 7'd0, 0},
      '{CMD_DATABASE,   6'd63, 5'd0,  8'sd0,    1'b0, 1'b0, 7'd0, 0},
      '{CMD_DATABASE,   6'd0,  5'd3,  8'sd0,    1'b1, 1'b0, 7'd0, 0}
   };

   phase_type phases[] = '{
      '{10,  1,   1,  0, 6,  57},
      '{0,   0,   32, 1, 6,  57},
      '{255, 255, 64, 0, 57, 6},
      '{3,   2,   17, 1, 0,  0},
      '{128, 7,   5,  0, 0,  0}
   };

   initial begin
      stim_type s;
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      configure(phases[0]);
      // all query symbols, and rows 0 to 31 of the table columns for database symbols 0 and 1
      // (the symbols the random phases use), are written before any column is scored
      s = '{CMD_LOAD_QUERY, 6'd0, 5'd0, 8'sd0, 1'b0, 1'b0, 7'd0, 0};
      for (int i = 0; i < MAX_QUERY; i++) begin
         s.row = ROW_BITS'(i);
         s.sym = SYM_BITS'($urandom_range(ALPHABET - 1));
         send(s);
      end
      s.cmd = CMD_LOAD_SCORE;
      for (int i = 0; i < PRELOAD_ROWS * DB_SYMS; i++) begin
         s.row = ROW_BITS'(i / DB_SYMS);
         s.sym = SYM_BITS'(i % DB_SYMS);
         s.val = VALUE_BITS'($urandom_range(255));
         send(s);
      end
      foreach (directed[k]) send(directed[k]);
      drain();
      for (int p = 1; p < phases.size(); p++) begin
         configure(phases[p]);
         for (int k = 0; k < RAND_ITEMS; k++) begin
            s.typed = 1'b0;
            s.row = ROW_BITS'($urandom_range(MAX_QUERY - 1));
            s.sym = SYM_BITS'($urandom_range(ALPHABET - 1));
            s.val = VALUE_BITS'($urandom_range(255));
            s.eod = ($urandom_range(9) == 0);
            pick = $urandom_range(99);
            if (k == RAND_ITEMS - 1) begin
               s.cmd = CMD_DATABASE;
               s.eod = 1'b1;
            end else if (pick < 75) s.cmd = CMD_DATABASE;
            else if (pick < 85) s.cmd = CMD_LOAD_SCORE;
            else if (pick < 95) s.cmd = CMD_LOAD_QUERY;
            else s.cmd = CMD_UNUSED;
            if (s.cmd == CMD_DATABASE) s.sym = SYM_BITS'($urandom_range(DB_SYMS - 1));
            send(s);
         end
         drain();
      end
      if (errors == 0 && trace_q.size() == 0) begin
         $display("PASS global_align_affine_trace_unit");
      end else begin
         $display("FAIL global_align_affine_trace_unit");
      end
      $finish;
   end

endmodule
